// ----- sv/tkc_pkg.sv -----
// Shared types and constants for the top-k-by-count selector.
// No dependencies; used by the interfaces, the cells, the register block and the top level.
package tkc_pkg;

  localparam int ID_W        = 32;
  localparam int COUNT_W     = 32;
  localparam int RANK_W      = 4;
  localparam int TOP_COUNT_W = 5;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int MAX_KEPT_DEF = 16;

  localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RST = TOP_COUNT_W'(16);

  // register indexes
  localparam logic [ADDR_W-3:0] REG_TOP_COUNT = '0;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctl_t;

endpackage

// ----- sv/tkc_ifs.sv -----
// Valid/ready channel interfaces for the selector's input and result words.
// Depends on tkc_pkg for field widths.
interface tkc_in_if;
  import tkc_pkg::*;
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    word_id;
  logic [COUNT_W-1:0] word_count;
  logic               last_word;

  modport source (output valid, word_id, word_count, last_word, input ready);
  modport sink   (input valid, word_id, word_count, last_word, output ready);
endinterface

interface tkc_out_if;
  import tkc_pkg::*;
  logic               valid;
  logic               ready;
  logic [RANK_W-1:0]  rank;
  logic [ID_W-1:0]    best_id;
  logic [COUNT_W-1:0] best_count;
  logic               last_result;

  modport source (output valid, rank, best_id, best_count, last_result, input ready);
  modport sink   (input valid, rank, best_id, best_count, last_result, output ready);
endinterface

// ----- sv/top_k_by_count_selector.sv -----
// Top-k selector: a chain of MAX_KEPT cells keeps the highest-count words in sorted order.
// One word per cycle is taken while no results drain; all cells compare against it in parallel
// and shift in one step. On a last word, results start the next cycle, one per cycle from
// cell 0 while out_ch.ready is high, n words for n kept. Input is held off while results drain.
// Synchronous active-low reset empties the chain and sets top_count to 16.
// Depends on tkc_pkg, tkc_ifs, tkc_cell and tkc_regs.
module top_k_by_count_selector #(
  parameter int MAX_KEPT = tkc_pkg::MAX_KEPT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tkc_in_if.sink                      in_ch,
  tkc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tkc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tkc_pkg::DATA_W-1:0]  pwdata,
  output logic [tkc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import tkc_pkg::*;

  localparam int LIM_W = $clog2(MAX_KEPT + 1);
  localparam int CMP_W = (LIM_W > TOP_COUNT_W) ? LIM_W : TOP_COUNT_W;

  logic [TOP_COUNT_W-1:0] top_count;
  logic [CMP_W-1:0]       tc_ext, lim;
  logic                   in_acc, out_acc;
  logic                   drain_r, drain_nxt;
  logic [RANK_W-1:0]      rank_r, rank_nxt;
  cell_ctl_t              ctl;
  entry_t                 ent [MAX_KEPT+1];
  entry_t                 prv [MAX_KEPT];
  logic [MAX_KEPT:0]      take_w;

  tkc_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .top_count
  );

  assign tc_ext = CMP_W'(top_count);
  always_comb begin
    if (tc_ext == '0) begin
      lim = CMP_W'(1);
    end else if (tc_ext > CMP_W'(MAX_KEPT)) begin
      lim = CMP_W'(MAX_KEPT);
    end else begin
      lim = tc_ext;
    end
  end

  assign in_ch.ready = ~drain_r;
  assign in_acc      = in_ch.valid & ~drain_r;
  assign out_acc     = drain_r & out_ch.ready;
  assign ctl.insert  = in_acc;
  assign ctl.drain   = out_acc;

  assign take_w[0]     = 1'b0;
  assign ent[MAX_KEPT] = '0;

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prv[i] = '0;
    end else begin : g_body
      assign prv[i] = ent[i-1];
    end
    tkc_cell u_cell (
      .clk, .rst_n,
      .ctl,
      .in_range  (CMP_W'(i) < lim),
      .new_id    (in_ch.word_id),
      .new_count (in_ch.word_count),
      .prev_take (take_w[i]),
      .prev_ent  (prv[i]),
      .next_ent  (ent[i+1]),
      .take      (take_w[i+1]),
      .ent       (ent[i])
    );
  end

  assign out_ch.valid       = drain_r;
  assign out_ch.rank        = rank_r;
  assign out_ch.best_id     = ent[0].id;
  assign out_ch.best_count  = ent[0].count;
  assign out_ch.last_result = ~ent[1].valid;

  always_comb begin
    drain_nxt = drain_r;
    rank_nxt  = rank_r;
    if (in_acc && in_ch.last_word) begin
      drain_nxt = 1'b1;
      rank_nxt  = '0;
    end else if (out_acc) begin
      rank_nxt = rank_r + RANK_W'(1);
      if (~ent[1].valid) begin
        drain_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      drain_r <= drain_nxt;
      rank_r  <= rank_nxt;
    end
  end

endmodule

// ----- sv/tkc_cell.sv -----
// One slot of the sorted insertion chain: holds an entry, inserts or shifts down on a word,
// shifts up while draining. Depends on tkc_pkg.
module tkc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tkc_pkg::cell_ctl_t ctl,
  input  logic               in_range,
  input  logic [tkc_pkg::ID_W-1:0]    new_id,
  input  logic [tkc_pkg::COUNT_W-1:0] new_count,
  input  logic               prev_take,
  input  tkc_pkg::entry_t    prev_ent,
  input  tkc_pkg::entry_t    next_ent,
  output logic               take,
  output tkc_pkg::entry_t    ent
);
  import tkc_pkg::*;

  logic               valid_r, valid_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               eff_valid;

  assign eff_valid = valid_r & in_range;
  // ties keep the older entry ahead
  assign take = in_range & (~eff_valid | (count_r < new_count));

  assign ent.valid = eff_valid;
  assign ent.id    = id_r;
  assign ent.count = count_r;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    count_nxt = count_r;
    if (ctl.insert) begin
      if (prev_take) begin
        valid_nxt = prev_ent.valid & in_range;
        id_nxt    = prev_ent.id;
        count_nxt = prev_ent.count;
      end else if (take) begin
        valid_nxt = 1'b1;
        id_nxt    = new_id;
        count_nxt = new_count;
      end else begin
        valid_nxt = eff_valid;
      end
    end else if (ctl.drain) begin
      valid_nxt = next_ent.valid;
      id_nxt    = next_ent.id;
      count_nxt = next_ent.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    id_r    <= id_nxt;
    count_r <= count_nxt;
  end

endmodule

// ----- sv/tkc_regs.sv -----
// APB-style configuration register block holding top_count.
// Depends on tkc_pkg.
module tkc_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tkc_pkg::ADDR_W-1:0]       paddr,
  input  logic [tkc_pkg::DATA_W-1:0]       pwdata,
  output logic [tkc_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  output logic [tkc_pkg::TOP_COUNT_W-1:0]  top_count
);
  import tkc_pkg::*;

  logic [TOP_COUNT_W-1:0] top_count_r;
  logic                   hit;

  assign pready    = 1'b1;
  assign top_count = top_count_r;
  assign hit       = (paddr[ADDR_W-1:2] == REG_TOP_COUNT);
  assign prdata    = hit ? DATA_W'(top_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= TOP_COUNT_RST;
    end else if (psel && penable && pwrite && pready && hit) begin
      top_count_r <= pwdata[TOP_COUNT_W-1:0];
    end
  end

endmodule

// ----- sv/tkc_checker.sv -----
// Port-level assertions for the top-k selector, bound onto the top level.
// Depends on tkc_pkg and top_k_by_count_selector.
module tkc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tkc_pkg::RANK_W-1:0] out_rank,
  input logic                       out_last
);
  import tkc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while results drain");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> out_valid && (out_rank == '0))
    else $error("last word did not start results at rank zero");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("results continue past final word");

endmodule

bind top_k_by_count_selector tkc_checker u_tkc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_word),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_rank  (out_ch.rank),
  .out_last  (out_ch.last_result)
);

// ----- tb/sv/top_k_by_count_selector_test.sv -----
`timescale 1ns / 1ps
// Testbench for top_k_by_count_selector: a directed table of words and limit writes, then
// random word sets, all checked against a ranking predictor. Depends on tkc_pkg and tkc_ifs.
module top_k_by_count_selector_test;
  import tkc_pkg::*;

  localparam int KEEP_MAX = 16;
  localparam int PHASE_WORDS = 150;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] count;
  } scored_t;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] count;
    logic               last;
  } ranked_word_t;

  typedef enum logic {ROW_WORD, ROW_LIMIT} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [ID_W-1:0]        id;
    logic [COUNT_W-1:0]     count;
    logic                   last;
    bit                     typed;
    logic [ID_W-1:0]        typed_id;
    logic [COUNT_W-1:0]     typed_count;
    logic [TOP_COUNT_W-1:0] limit;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tkc_in_if  word_ch ();
  tkc_out_if rank_ch ();

  top_k_by_count_selector u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (word_ch),
    .out_ch  (rank_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scored_t                kept [KEEP_MAX];
  int unsigned            kept_fill = 0;
  logic [TOP_COUNT_W-1:0] limit_shadow = TOP_COUNT_RST;
  ranked_word_t           expected_ranks [$];
  ranked_word_t           drained [$];
  row_t                   rows [$];
  int                     send_idle_pct = 8;
  int                     recv_idle_pct = 70;
  int                     mismatches = 0;
  int                     words_sent = 0;
  bit                     long_hold_go = 1'b0;
  bit                     long_hold_done = 1'b0;
  int                     hold_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("top_k_by_count_selector regression: fail");
    $finish;
  end

  function automatic void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Insert one word into the sorted store; on a last word, drain it highest count first.
  function automatic void rank_word(logic [ID_W-1:0] id, logic [COUNT_W-1:0] cnt, logic last);
    int unsigned lim;
    int unsigned pos;
    int unsigned top;
    lim = limit_shadow;
    if (lim < 1) lim = 1;
    if (lim > KEEP_MAX) lim = KEEP_MAX;
    if (kept_fill > lim) kept_fill = lim;
    pos = 0;
    while (pos < kept_fill && kept[pos].count >= cnt) pos++;
    top = KEEP_MAX;
    if (kept_fill < lim) begin
      top = kept_fill;
      kept_fill++;
    end else if (pos < kept_fill) begin
      top = kept_fill - 1;
    end
    if (top != KEEP_MAX) begin
      for (int unsigned j = top; j > pos; j--) kept[j] = kept[j-1];
      kept[pos] = scored_t'{id, cnt};
    end
    drained.delete();
    if (last) begin
      for (int unsigned k = 0; k < kept_fill; k++) begin
        drained.push_back(ranked_word_t'{RANK_W'(k), kept[k].id, kept[k].count,
                                         k + 1 == kept_fill});
      end
      kept_fill = 0;
    end
  endfunction

  function automatic void add_word(logic [ID_W-1:0] id, logic [COUNT_W-1:0] cnt, logic last,
                                   bit typed = 1'b0, logic [ID_W-1:0] tid = '0,
                                   logic [COUNT_W-1:0] tcnt = '0);
    row_t r;
    r = '{ROW_WORD, id, cnt, last, typed, tid, tcnt, '0};
    rows.push_back(r);
  endfunction

  function automatic void add_limit(logic [TOP_COUNT_W-1:0] value);
    row_t r;
    r = '{ROW_LIMIT, '0, '0, 1'b0, 1'b0, '0, '0, value};
    rows.push_back(r);
  endfunction

  task automatic send_word(logic [ID_W-1:0] id, logic [COUNT_W-1:0] cnt, logic last,
                           bit typed = 1'b0, logic [ID_W-1:0] tid = '0,
                           logic [COUNT_W-1:0] tcnt = '0);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      word_ch.valid <= 1'b0;
      @(posedge clk);
    end
    word_ch.valid      <= 1'b1;
    word_ch.word_id    <= id;
    word_ch.word_count <= cnt;
    word_ch.last_word  <= last;
    do @(posedge clk); while (!word_ch.ready);
    rank_word(id, cnt, last);
    if (typed) begin
      expected_ranks.push_back(ranked_word_t'{'0, tid, tcnt, 1'b1});
    end else begin
      foreach (drained[k]) expected_ranks.push_back(drained[k]);
    end
    words_sent++;
  endtask

  // Drop valid and wait until every expected word is out.
  task automatic settle();
    word_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_ranks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [TOP_COUNT_W-1:0] value);
    logic [DATA_W-1:0] back;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TOP_COUNT, 2'b00};
    pwdata  <= DATA_W'({$urandom, value});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_shadow = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (back[TOP_COUNT_W-1:0] !== value)
      flag($sformatf("top_count readback: expected %0d got %0d", value, back[TOP_COUNT_W-1:0]));
  endtask

  task automatic send_set();
    int unsigned size;
    int unsigned style;
    int unsigned cut;
    logic [COUNT_W-1:0] cnt;
    size  = $urandom_range(1, 24);
    style = $urandom_range(3);
    cut   = (size > 1 && $urandom_range(7) == 0) ? $urandom_range(1, size - 1) : 0;
    for (int unsigned n = 0; n < size; n++) begin
      if (cut != 0 && n == cut) begin
        settle();
        write_limit(TOP_COUNT_W'($urandom_range(0, 31)));
      end
      case (style)
        0: cnt = $urandom_range(0, 15);
        1: cnt = $urandom;
        2: case ($urandom_range(3))
             0: cnt = '0;
             1: cnt = 32'd1;
             2: cnt = 32'hFFFF_FFFE;
             default: cnt = 32'hFFFF_FFFF;
           endcase
        default: cnt = $urandom_range(0, 1000);
      endcase
      send_word($urandom, cnt, n + 1 == size);
    end
  endtask

  always @(posedge clk) begin : rank_monitor
    ranked_word_t want;
    ranked_word_t got;
    if (rst_n && rank_ch.valid && rank_ch.ready) begin
      got = '{rank_ch.rank, rank_ch.best_id, rank_ch.best_count, rank_ch.last_result};
      if (expected_ranks.size() == 0) begin
        flag($sformatf("unexpected word: rank %0d id %h count %h last %b",
                       got.rank, got.id, got.count, got.last));
      end else begin
        want = expected_ranks.pop_front();
        if (got !== want)
          flag($sformatf({"word mismatch: expected rank %0d id %h count %h last %b,",
                          " got rank %0d id %h count %h last %b"},
                         want.rank, want.id, want.count, want.last,
                         got.rank, got.id, got.count, got.last));
      end
    end
  end

  // receiver side: random idling, and one long hold counted here
  always @(posedge clk) begin : rank_ready_drive
    if (long_hold_go && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left      <= 400;
      rank_ch.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      rank_ch.ready <= 1'b0;
    end else begin
      rank_ch.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  initial begin
    int base;
    word_ch.valid      = 1'b0;
    word_ch.word_id    = '0;
    word_ch.word_count = '0;
    word_ch.last_word  = 1'b0;
    rank_ch.ready      = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_word(32'h0, 32'h0, 1'b1, 1'b1, 32'h0, 32'h0);
    add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_limit(5'd1);
    add_word(32'hA1, 32'd5, 1'b0);
    add_word(32'hB2, 32'd5, 1'b0);
    add_word(32'hC3, 32'd3, 1'b0);
    add_word(32'hD4, 32'd6, 1'b1, 1'b1, 32'hD4, 32'd6);
    add_word(32'hE5, 32'd7, 1'b0);
    add_word(32'hF6, 32'd7, 1'b1, 1'b1, 32'hE5, 32'd7);
    add_limit(5'd0);
    add_word(32'd1, 32'd9, 1'b0);
    add_word(32'd2, 32'd10, 1'b1, 1'b1, 32'd2, 32'd10);
    add_limit(5'd31);
    add_word(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    add_word(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    add_word(32'd1, 32'hAAAA_AAAA, 1'b0);
    add_word(32'd2, 32'd0, 1'b1);
    add_limit(5'd3);
    add_word(32'h10, 32'd1, 1'b0);
    add_word(32'h11, 32'd2, 1'b0);
    add_word(32'h12, 32'd3, 1'b0);
    add_word(32'h13, 32'd4, 1'b0);
    add_limit(5'd2);  // lowered with three words kept
    add_word(32'h14, 32'd0, 1'b1);
    add_limit(5'd16);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_LIMIT) begin
        settle();
        write_limit(rows[i].limit);
      end else begin
        send_word(rows[i].id, rows[i].count, rows[i].last, rows[i].typed,
                  rows[i].typed_id, rows[i].typed_count);
      end
    end

    base = words_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          long_hold_go  = 1'b1;
        end
      endcase
      while (words_sent < base + PHASE_WORDS * (phase + 1)) begin
        if ($urandom_range(3) == 0) begin
          settle();
          case ($urandom_range(3))
            0: write_limit(TOP_COUNT_W'($urandom_range(0, 1)));
            1: write_limit(TOP_COUNT_W'($urandom_range(16, 31)));
            default: write_limit(TOP_COUNT_W'($urandom_range(2, 15)));
          endcase
        end
        send_set();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_ranks.size() == 0) begin
      $display("top_k_by_count_selector regression: pass");
    end else begin
      $display("top_k_by_count_selector regression: fail");
    end
    $finish;
  end

endmodule

// ----- top_k_by_count_selector.f -----
sv/tkc_pkg.sv
sv/tkc_ifs.sv
sv/tkc_cell.sv
sv/tkc_regs.sv
sv/top_k_by_count_selector.sv
sv/tkc_checker.sv
tb/sv/top_k_by_count_selector_test.sv
